// File: src/smd5_pkg.sv
// Package for the seeded MD5 hash engine.
// Holds the MD5 initial values, seed multipliers, round tables and the queue entry type.
package smd5_pkg;

   localparam logic [31:0] IV0 = 32'h67452301;
   localparam logic [31:0] IV1 = 32'hefcdab89;
   localparam logic [31:0] IV2 = 32'h98badcfe;
   localparam logic [31:0] IV3 = 32'h10325476;
   localparam logic [6:0]  MUL0 = 7'd11;
   localparam logic [6:0]  MUL1 = 7'd71;
   localparam logic [6:0]  MUL2 = 7'd37;
   localparam logic [6:0]  MUL3 = 7'd97;
   localparam logic [7:0]  PAD_BYTE = 8'h80;
   localparam logic [5:0]  LEN_POS = 6'd56;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_message;
   } item_type;

   function automatic logic [31:0] round_const(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
         6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
         6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
         6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
         6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
         6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
         6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
         6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
         6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
         6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
         6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
         6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
         default: k = 32'heb86d391;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] rot_amount(input logic [3:0] j);
      logic [4:0] s;
      case (j)
         4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
         4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
         4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
         4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
      endcase
      return s;
   endfunction

endpackage

// File: src/smd5_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module smd5_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// File: src/smd5_queue.sv
// Two-entry queue between the request front end and the hash back end.
// Depends on smd5_pkg for the entry type.
module smd5_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  smd5_pkg::item_type in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output smd5_pkg::item_type out_item
);
   smd5_pkg::item_type slot_ff [2];
   logic               wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule

// File: src/smd5_back.sv
// Hash back end: block buffer, padding sequencer, one MD5 round per cycle, digest output.
// Depends on smd5_pkg and smd5_ram.
module smd5_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               cfg_we,
   input  logic [31:0]        seed,
   input  logic               in_valid,
   output logic               in_ready,
   input  smd5_pkg::item_type in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [31:0]        out_word,
   output logic [1:0]         out_index
);
   typedef enum logic [2:0] {
      S_IDLE, S_LOAD, S_ROUND, S_FOLD, S_PAD, S_EMIT
   } state_type;

   state_type   state_ff;
   logic [5:0]  fill_ff;
   logic [63:0] bits_ff, len_ff;
   logic [31:0] h_ff [4];
   logic [31:0] m_ff [16];
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [5:0]  cnt_ff;
   logic        closing_ff, pad_ff, lenblk_ff;
   logic [1:0]  widx_ff;
   logic [31:0] seed_ff;
   logic        reload_ff;

   logic        ram_we;
   logic [5:0]  ram_wa, ram_ra;
   logic [7:0]  ram_wd, ram_rd;
   logic [5:0]  round;
   logic [31:0] f, t, sum, rot;
   logic [3:0]  g;
   logic [4:0]  sh;
   logic [7:0]  pad_data;

   smd5_ram #(.WIDTH(8), .DEPTH(64)) u_buf (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
      .rd_addr(ram_ra), .rd_data(ram_rd)
   );

   assign round = cnt_ff;
   assign ram_ra = cnt_ff;

   always_comb begin
      case (round[5:4])
         2'd0: begin
            f = (b_ff & c_ff) | (~b_ff & d_ff);
            g = round[3:0];
         end
         2'd1: begin
            f = (b_ff & d_ff) | (c_ff & ~d_ff);
            g = 4'(round[3:0] * 4'd5 + 4'd1);
         end
         2'd2: begin
            f = b_ff ^ c_ff ^ d_ff;
            g = 4'(round[3:0] * 4'd3 + 4'd5);
         end
         default: begin
            f = c_ff ^ (b_ff | ~d_ff);
            g = 4'(round[3:0] * 4'd7);
         end
      endcase
      sh  = smd5_pkg::rot_amount({round[5:4], round[1:0]});
      t   = a_ff + f + m_ff[g] + smd5_pkg::round_const(round);
      rot = (t << sh) | (t >> (6'd32 - {1'b0, sh}));
      sum = b_ff + rot;
   end

   always_comb begin
      if (!pad_ff) begin
         pad_data = smd5_pkg::PAD_BYTE;
      end else if (lenblk_ff && fill_ff >= smd5_pkg::LEN_POS) begin
         pad_data = len_ff[{fill_ff[2:0], 3'b000} +: 8];
      end else begin
         pad_data = 8'h00;
      end
   end

   assign in_ready  = (state_ff == S_IDLE) && !reload_ff;
   assign out_valid = (state_ff == S_EMIT);
   assign out_word  = h_ff[widx_ff];
   assign out_index = widx_ff;

   always_comb begin
      ram_we = 1'b0;
      ram_wa = fill_ff;
      ram_wd = in_item.data_byte;
      if (state_ff == S_IDLE && in_valid && in_ready && in_item.byte_valid) begin
         ram_we = 1'b1;
      end else if (state_ff == S_PAD) begin
         ram_we = 1'b1;
         ram_wd = pad_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         fill_ff    <= 6'd0;
         bits_ff    <= 64'd0;
         closing_ff <= 1'b0;
         pad_ff     <= 1'b0;
         lenblk_ff  <= 1'b0;
         widx_ff    <= 2'd0;
         cnt_ff     <= 6'd0;
         seed_ff    <= 32'd0;
         reload_ff  <= 1'b1;
      end else begin
         if (cfg_we) begin
            seed_ff   <= seed;
            reload_ff <= 1'b1;
         end
         case (state_ff)
            S_IDLE: begin
               if (reload_ff && !cfg_we) begin
                  reload_ff <= 1'b0;
                  fill_ff   <= 6'd0;
                  bits_ff   <= 64'd0;
                  h_ff[0]   <= 32'(seed_ff * 32'(smd5_pkg::MUL0)) + smd5_pkg::IV0;
                  h_ff[1]   <= 32'(seed_ff * 32'(smd5_pkg::MUL1)) + smd5_pkg::IV1;
                  h_ff[2]   <= 32'(seed_ff * 32'(smd5_pkg::MUL2)) + smd5_pkg::IV2;
                  h_ff[3]   <= 32'(seed_ff * 32'(smd5_pkg::MUL3)) + smd5_pkg::IV3;
               end else if (in_valid && in_ready) begin
                  closing_ff <= in_item.end_of_message;
                  pad_ff     <= 1'b0;
                  lenblk_ff  <= 1'b0;
                  if (in_item.byte_valid) begin
                     fill_ff <= fill_ff + 6'd1;
                     bits_ff <= bits_ff + 64'd8;
                     len_ff  <= bits_ff + 64'd8;
                  end else begin
                     len_ff <= bits_ff;
                  end
                  if (in_item.byte_valid && fill_ff == 6'd63) begin
                     cnt_ff   <= 6'd0;
                     state_ff <= S_LOAD;
                  end else if (in_item.end_of_message) begin
                     state_ff <= S_PAD;
                  end
               end
            end
            S_PAD: begin
               pad_ff  <= 1'b1;
               if (!pad_ff && fill_ff < smd5_pkg::LEN_POS) begin
                  lenblk_ff <= 1'b1;
               end
               fill_ff <= fill_ff + 6'd1;
               if (fill_ff == 6'd63) begin
                  cnt_ff   <= 6'd0;
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD: begin
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff != 6'd0) begin
                  m_ff[cnt_ff[5:2] - 4'd1 + (cnt_ff[1:0] == 2'd0 ? 4'd0 : 4'd1)]
                     [{cnt_ff[1:0] - 2'd1, 3'b000} +: 8] <= ram_rd;
               end
               if (cnt_ff == 6'd63) begin
                  state_ff <= S_ROUND;
               end
               a_ff <= h_ff[0];
               b_ff <= h_ff[1];
               c_ff <= h_ff[2];
               d_ff <= h_ff[3];
            end
            S_ROUND: begin
               if (cnt_ff == 6'd0) begin
                  m_ff[15][31:24] <= ram_rd;
               end
               a_ff   <= d_ff;
               d_ff   <= c_ff;
               c_ff   <= b_ff;
               b_ff   <= sum;
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd63) begin
                  state_ff <= S_FOLD;
               end
            end
            S_FOLD: begin
               h_ff[0] <= h_ff[0] + a_ff;
               h_ff[1] <= h_ff[1] + b_ff;
               h_ff[2] <= h_ff[2] + c_ff;
               h_ff[3] <= h_ff[3] + d_ff;
               if (closing_ff && lenblk_ff) begin
                  widx_ff  <= 2'd0;
                  state_ff <= S_EMIT;
               end else if (closing_ff) begin
                  if (pad_ff) begin
                     lenblk_ff <= 1'b1;
                  end
                  state_ff <= S_PAD;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_EMIT: begin
               if (out_ready) begin
                  widx_ff <= widx_ff + 2'd1;
                  if (widx_ff == 2'd3) begin
                     reload_ff <= 1'b1;
                     state_ff  <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// File: src/seeded_md5_hash_engine_core.sv
// Top level of the seeded MD5 hash engine: request front end, queue, hash back end.
// Depends on smd5_pkg, smd5_queue, smd5_back and smd5_ram.
//
//   channel  direction  tdata                       tuser / tlast
//   req      in         data_byte[7:0]              tuser[0] byte_valid, tlast end_of_message
//   rsp      out        digest_word[31:0]           tuser[1:0] word_index, tlast last_word
//   csr      in         seed[31:0]                  none
//
// A request is stored in a queue slot and then taken by the back end. A filled block is
// read from the block buffer one byte at a time, run through 64 rounds on the single round
// unit and folded into the chain words. End of message writes one padding byte per cycle
// to the end of the block and runs one or two more blocks, then sends four digest words,
// one per cycle while rsp_tready is high, and reloads the chain words from the seed. Reset
// is synchronous; the chain words load from the seed in an idle cycle with no seed write.
// The queue takes requests while the back end works or rsp stalls, until it holds two.
module seeded_md5_hash_engine_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tuser,   // byte_valid
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // digest_word
   output logic [1:0]  rsp_tuser,   // word_index
   output logic        rsp_tlast,   // last_word
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data     // seed
);
   smd5_pkg::item_type req_item, q_item;
   logic q_valid, q_ready;

   assign req_item = '{data_byte: req_tdata, byte_valid: req_tuser, end_of_message: req_tlast};
   assign csr_ready = 1'b1;

   smd5_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_item(req_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   smd5_back u_back (
      .clock(clock), .reset(reset),
      .cfg_we(csr_valid && csr_ready), .seed(csr_data),
      .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_word(rsp_tdata), .out_index(rsp_tuser)
   );

   assign rsp_tlast = (rsp_tuser == 2'd3);

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == 2'd3) else $error("last flag off index");
   a_word_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && rsp_tuser == $past(rsp_tuser) + 2'd1)
      else $error("digest words out of order");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !q_ready) else $error("back end took a request while emitting");
endmodule
